[sv/qcd_pkg.sv]
// shared types, constants and decode functions for the quadrature counter with display
`timescale 1ns / 1ps
package qcd_pkg;

   localparam int COUNT_W          = 10;
   localparam int COUNT_TOP        = 1023;
   localparam int DEBOUNCE_SAMPLES = 12;
   localparam int HIST_W           = DEBOUNCE_SAMPLES + 1;
   localparam int SUM_W            = COUNT_W + 2;

   localparam logic [HIST_W-1:0]  HIST_PRESS = HIST_W'(1) << DEBOUNCE_SAMPLES;
   localparam logic [SUM_W-1:0]   SUM_TOP    = SUM_W'(COUNT_TOP);
   localparam logic [COUNT_W-1:0] COUNT_MAX  = COUNT_W'(COUNT_TOP);

   localparam logic [1:0] MODE_SINGLE = 2'd0;
   localparam logic [1:0] MODE_DOUBLE = 2'd1;
   localparam logic [1:0] MODE_QUAD   = 2'd2;
   localparam logic [1:0] MODE_OFF    = 2'd3;

   localparam logic [2:0] POS_ONES      = 3'd0;
   localparam logic [2:0] POS_TENS      = 3'd1;
   localparam logic [2:0] POS_COLON     = 3'd2;
   localparam logic [2:0] POS_HUNDREDS  = 3'd3;
   localparam logic [2:0] POS_THOUSANDS = 3'd4;

   localparam logic [7:0] SEG_BLANK = 8'hFF;

   typedef struct packed {
      logic [1:0]         mode;
      logic [COUNT_W-1:0] count;
      logic [2:0]         pos;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // signed step for one encoder, -1..1
   function automatic logic signed [1:0] edge_delta(input logic [1:0] prev,
                                                    input logic [1:0] cur,
                                                    input logic [1:0] mode);
      logic [3:0] code;
      logic       dbl;
      logic       quad;
      logic signed [1:0] d;
      code = {prev, cur};
      dbl  = (mode == MODE_DOUBLE) || (mode == MODE_QUAD);
      quad = (mode == MODE_QUAD);
      d    = 2'sd0;
      case (code)
         4'h1:              d = 2'sd1;
         4'h4:              d = -2'sd1;
         4'hE:              d = dbl ? 2'sd1 : 2'sd0;
         4'hB:              d = dbl ? -2'sd1 : 2'sd0;
         4'h8, 4'h7:        d = quad ? 2'sd1 : 2'sd0;
         4'h2, 4'hD:        d = quad ? -2'sd1 : 2'sd0;
         default:           d = 2'sd0;
      endcase
      if (mode == MODE_OFF) begin
         d = 2'sd0;
      end
      return d;
   endfunction

   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] s;
      case (digit)
         4'd0:    s = 8'hC0;
         4'd1:    s = 8'hF9;
         4'd2:    s = 8'hA4;
         4'd3:    s = 8'hB0;
         4'd4:    s = 8'h99;
         4'd5:    s = 8'h92;
         4'd6:    s = 8'h83;
         4'd7:    s = 8'hF8;
         4'd8:    s = 8'h80;
         4'd9:    s = 8'h98;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] bar_pattern(input logic [1:0] mode);
      logic [7:0] b;
      unique case (mode)
         MODE_SINGLE: b = 8'h01;
         MODE_DOUBLE: b = 8'h03;
         MODE_QUAD:   b = 8'h0F;
         MODE_OFF:    b = 8'hFF;
         default:     b = 8'hFF;
      endcase
      return b;
   endfunction

endpackage

[sv/qcd_front.sv]
// front end: debounce, mode toggle, quadrature decode, count wrap, scan rotation
`timescale 1ns / 1ps
module qcd_front
   import qcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [1:0] button_raw,
   input  logic [3:0] encoder_bits,
   output entry_type  entry
);

   logic [HIST_W-1:0]  hist_ff [2];
   logic [HIST_W-1:0]  hist_in [2];
   logic [1:0]         mode_ff, mode_in;
   logic [3:0]         prev_ab_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [2:0]         scan_ff, scan_in, pos;
   logic signed [SUM_W-1:0] sum;
   logic [1:0]         toggle;

   always_comb begin
      for (int b = 0; b < 2; b++) begin
         hist_in[b] = {hist_ff[b][HIST_W-2:0], button_raw[b]};
         toggle[b]  = (hist_in[b] == HIST_PRESS);
      end
      mode_in = mode_ff ^ toggle;
      sum = $signed({2'b00, count_ff})
          + SUM_W'(edge_delta(prev_ab_ff[1:0], encoder_bits[1:0], mode_in))
          + SUM_W'(edge_delta(prev_ab_ff[3:2], encoder_bits[3:2], mode_in));
      if (sum > $signed(SUM_TOP)) begin
         count_in = COUNT_W'(1);
      end else if (sum < 0) begin
         count_in = COUNT_MAX;
      end else begin
         count_in = sum[COUNT_W-1:0];
      end
      pos     = (scan_ff > POS_THOUSANDS) ? POS_ONES : scan_ff;
      scan_in = (pos >= POS_THOUSANDS) ? POS_ONES : pos + 3'd1;
      entry.mode  = mode_in;
      entry.count = count_in;
      entry.pos   = pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff[0] <= '0;
         hist_ff[1] <= '0;
         mode_ff    <= MODE_SINGLE;
         prev_ab_ff <= '0;
         count_ff   <= '0;
         scan_ff    <= POS_ONES;
      end else if (accept) begin
         hist_ff[0] <= hist_in[0];
         hist_ff[1] <= hist_in[1];
         mode_ff    <= mode_in;
         prev_ab_ff <= encoder_bits;
         count_ff   <= count_in;
         scan_ff    <= scan_in;
      end
   end

endmodule

[sv/qcd_queue.sv]
// two-entry queue between front and back
`timescale 1ns / 1ps
module qcd_queue
   import qcd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  entry_type      push_entry,
   input  logic           pop,
   output entry_type      head,
   output queue_stat_type stat
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;

   assign stat.full  = (fill_ff == 2'd2);
   assign stat.empty = (fill_ff == 2'd0);
   assign head       = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

[sv/qcd_back.sv]
// back end: digit extraction, segment lookup and output register
`timescale 1ns / 1ps
module qcd_back
   import qcd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  entry_type          head,
   input  logic               head_valid,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         bar_leds,
   output logic [COUNT_W-1:0] count_value,
   output logic [7:0]         segment_byte,
   output logic [2:0]         digit_index
);

   logic               valid_ff;
   logic [7:0]         bar_ff, seg_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [2:0]         pos_ff;
   logic [7:0]         seg_in;
   logic [17:0]        prod10;
   logic [15:0]        prod100;
   logic [6:0]         q10;
   logic [3:0]         q100;
   logic [3:0]         ones, tens, hund;
   logic [COUNT_W-1:0] v;

   assign pop = head_valid && (!valid_ff || rsp_ready);

   always_comb begin
      v       = head.count;
      prod10  = 18'(v) * 18'd205;
      prod100 = 16'(v) * 16'd41;
      q10     = prod10[17:11];
      q100    = prod100[15:12];
      ones    = 4'(v - ((COUNT_W'(q10) << 3) + (COUNT_W'(q10) << 1)));
      tens    = 4'(q10 - ((7'(q100) << 3) + (7'(q100) << 1)));
      hund    = (q100 == 4'd10) ? 4'd0 : q100;
      unique case (head.pos)
         POS_ONES:      seg_in = seg_pattern(ones);
         POS_TENS:      seg_in = (v < 10'd10) ? SEG_BLANK : seg_pattern(tens);
         POS_HUNDREDS:  seg_in = (v < 10'd100) ? SEG_BLANK : seg_pattern(hund);
         POS_THOUSANDS: seg_in = (v < 10'd1000) ? SEG_BLANK : seg_pattern(4'd1);
         default:       seg_in = SEG_BLANK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         bar_ff   <= bar_pattern(head.mode);
         count_ff <= head.count;
         seg_ff   <= seg_in;
         pos_ff   <= head.pos;
      end
   end

   assign rsp_valid    = valid_ff;
   assign bar_leds     = bar_ff;
   assign count_value  = count_ff;
   assign segment_byte = seg_ff;
   assign digit_index  = pos_ff;

endmodule

[sv/quadrature_counter_with_display_unit.sv]
// top level of the quadrature counter with mode buttons, bargraph and scanned display
`timescale 1ns / 1ps
// One req transfer is one timer tick and gives exactly one rsp transfer. A tick can be
// taken every clock cycle while the queue is not full; its result passes through the queue
// and the back-end output register before it shows on rsp. The front end updates the
// debounce, mode, count and scan state once per tick, a two-entry queue separates it from
// the back end, and the back end turns the count into the selected display digit into an
// output register. req_tready drops only while the queue is full.
module quadrature_counter_with_display_unit
   import qcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // button_raw[1:0], encoder_bits[5:2], zero[7:6]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // bar_leds[7:0], count_value[17:8], segment_byte[25:18],
                                    // digit_index[28:26], zero[31:29]
);

   logic               accept;
   logic               pop;
   entry_type          front_entry, head;
   queue_stat_type     qstat;
   logic [7:0]         bar_leds, segment_byte;
   logic [COUNT_W-1:0] count_value;
   logic [2:0]         digit_index;

   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;

   qcd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .button_raw   (req_tdata[1:0]),
      .encoder_bits (req_tdata[5:2]),
      .entry        (front_entry)
   );

   qcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (front_entry),
      .pop        (pop),
      .head       (head),
      .stat       (qstat)
   );

   qcd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_valid   (!qstat.empty),
      .pop          (pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .bar_leds     (bar_leds),
      .count_value  (count_value),
      .segment_byte (segment_byte),
      .digit_index  (digit_index)
   );

   assign rsp_tdata = {3'b000, digit_index, segment_byte, count_value, bar_leds};

endmodule
